// ----- src/bmh_pkg.sv -----
// Shared widths and codes of the binary max-heap unit.
`default_nettype none

package bmh_pkg;

  // Width of one stored key.
  localparam int unsigned KEY_W = 32;
  // Width of the capacity register and of the reported count.
  localparam int unsigned CAP_W = 11;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } req_e;

endpackage

`default_nettype wire

// ----- src/bmh_mem.sv -----
// Key store of the heap: one write port and two registered read ports.
`default_nettype none

module bmh_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire logic                                clk_i,
  input  wire logic                                we_i,
  input  wire logic [AW-1:0]                       waddr_i,
  input  wire logic signed [bmh_pkg::KEY_W-1:0]    wdata_i,
  input  wire logic [AW-1:0]                       ra_addr_i,
  output logic signed [bmh_pkg::KEY_W-1:0]         ra_data_o,
  input  wire logic [AW-1:0]                       rb_addr_i,
  output logic signed [bmh_pkg::KEY_W-1:0]         rb_data_o
);

  logic signed [bmh_pkg::KEY_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Reads return the contents from before a write in the same cycle.
  always_ff @(posedge clk_i) begin
    ra_data_o <= mem_q[ra_addr_i];
    rb_data_o <= mem_q[rb_addr_i];
  end

endmodule

`default_nettype wire

// ----- src/binary_max_heap_unit.sv -----
// Top level of the binary max-heap priority queue with its sift sequencer.
//
// Usage: each input beat is a request. An insert (req_type 0) places a signed
// 32-bit key in the heap; a removal (req_type 1) takes out the largest key.
// Every request yields exactly one output beat with a status (ok, full or
// empty), the removed key (zero unless a removal succeeded) and the number of
// keys held afterwards. Both channels use valid/stall: a beat moves on a
// rising edge where valid is high and stall is low.
// One request is worked on at a time. Each heap level that a key moves through (at
// most log2 of HEAP_DEPTH, so ten for the default depth) is one read-compare-write
// round trip through the registered read of the key store, with both children
// fetched together on removal. A refused request goes straight to its result
// without touching the store.
// Reset clears the count (the heap is empty) and sets the capacity to 1024;
// the store itself is not cleared, since only filled positions are read.
// A finished result waits in the output register; the next request is taken
// while it waits, but its own result is held back until the receiver drains
// the previous one. The capacity is written through its own valid/ready port;
// the user must write it only while the unit is idle, as the unit does not enforce it.
`default_nettype none

module binary_max_heap_unit #(
  parameter int unsigned HEAP_DEPTH = 1024
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Capacity write port.
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [bmh_pkg::CAP_W-1:0]         cfg_capacity_i,
  // Request channel.
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              in_req_type_i,
  input  wire logic signed [bmh_pkg::KEY_W-1:0]  in_key_i,
  // Result channel.
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [1:0]                             out_status_o,
  output logic signed [bmh_pkg::KEY_W-1:0]       out_max_key_o,
  output logic [bmh_pkg::CAP_W-1:0]              out_count_o
);

  // Heap positions run from 1 to the count; the store address is position - 1.
  localparam int unsigned CNT_W = $clog2(HEAP_DEPTH + 1);
  // Child positions can reach twice the count plus one.
  localparam int unsigned CW    = CNT_W + 1;
  localparam int unsigned AW    = $clog2(HEAP_DEPTH);
  localparam int unsigned CMP_W = (CNT_W > bmh_pkg::CAP_W) ? CNT_W : bmh_pkg::CAP_W;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_INS_CMP  = 7'b0000010,
    S_INS_WR   = 7'b0000100,
    S_REM_LOAD = 7'b0001000,
    S_REM_CMP  = 7'b0010000,
    S_REM_WR   = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [bmh_pkg::CAP_W-1:0]         cap_q;
  logic [CNT_W-1:0]                  count_q, count_d;
  logic [CNT_W-1:0]                  pos_q, pos_d;
  logic [CW-1:0]                     child_q, child_d;
  logic signed [bmh_pkg::KEY_W-1:0]  key_q, key_d;
  logic signed [bmh_pkg::KEY_W-1:0]  removed_q, removed_d;
  bmh_pkg::status_e                  status_q, status_d;

  logic                              out_valid_q;
  bmh_pkg::status_e                  out_status_q;
  logic signed [bmh_pkg::KEY_W-1:0]  out_key_q;
  logic [bmh_pkg::CAP_W-1:0]         out_count_q;
  logic                              load_out;

  // Store port signals, in heap positions.
  logic                              mem_we;
  logic [CNT_W-1:0]                  mem_wpos;
  logic signed [bmh_pkg::KEY_W-1:0]  mem_wdata;
  logic [CW-1:0]                     ra_pos, rb_pos;
  logic signed [bmh_pkg::KEY_W-1:0]  ra_data, rb_data;

  // Sift helpers.
  logic [CNT_W-1:0]                  pos_ins;
  logic [CNT_W-1:0]                  parent_pos;
  logic [CW-1:0]                     sel_pos;
  logic signed [bmh_pkg::KEY_W-1:0]  sel_val;
  logic [CW-1:0]                     next_child;
  logic [CNT_W-1:0]                  count_dec;
  logic                              heap_full;
  logic [CMP_W-1:0]                  count_ext;

  bmh_mem #(
    .DEPTH (HEAP_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (AW'(mem_wpos - CNT_W'(1))),
    .wdata_i   (mem_wdata),
    .ra_addr_i (AW'(ra_pos - CW'(1))),
    .ra_data_o (ra_data),
    .rb_addr_i (AW'(rb_pos - CW'(1))),
    .rb_data_o (rb_data)
  );

  // The capacity register can always take a write.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= bmh_pkg::CAP_W'(1024);
    end else if (cfg_valid_i) begin
      cap_q <= cfg_capacity_i;
    end
  end

  // A capacity above the store depth acts as the depth.
  assign count_ext = CMP_W'(count_q);
  assign heap_full = (count_ext >= CMP_W'(cap_q)) || (count_q == CNT_W'(HEAP_DEPTH));

  assign pos_ins    = count_q + CNT_W'(1);
  assign parent_pos = pos_q >> 1;
  assign count_dec  = count_q - CNT_W'(1);

  // On removal, take the right child only when it exists and is strictly larger.
  always_comb begin
    if ((child_q < CW'(count_q)) && (rb_data > ra_data)) begin
      sel_pos = child_q + CW'(1);
      sel_val = rb_data;
    end else begin
      sel_pos = child_q;
      sel_val = ra_data;
    end
    next_child = sel_pos << 1;
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    pos_d     = pos_q;
    child_d   = child_q;
    key_d     = key_q;
    removed_d = removed_q;
    status_d  = status_q;
    mem_we    = 1'b0;
    mem_wpos  = pos_q;
    mem_wdata = key_q;
    ra_pos    = CW'(1);
    rb_pos    = CW'(count_q);
    load_out  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        // Fetch the new key's parent, or the root and the last key, ahead of time.
        if (in_req_type_i == bmh_pkg::REQ_INSERT) begin
          ra_pos = CW'(pos_ins >> 1);
        end
        if (in_valid_i) begin
          status_d  = bmh_pkg::ST_OK;
          removed_d = '0;
          if (in_req_type_i == bmh_pkg::REQ_INSERT) begin
            if (heap_full) begin
              status_d = bmh_pkg::ST_FULL;
              state_d  = S_DONE;
            end else begin
              count_d = pos_ins;
              pos_d   = pos_ins;
              key_d   = in_key_i;
              state_d = (count_q == '0) ? S_INS_WR : S_INS_CMP;
            end
          end else begin
            if (count_q == '0) begin
              status_d = bmh_pkg::ST_EMPTY;
              state_d  = S_DONE;
            end else begin
              state_d = S_REM_LOAD;
            end
          end
        end
      end

      S_INS_CMP: begin
        mem_we   = 1'b1;
        mem_wpos = pos_q;
        if (ra_data < key_q) begin
          // Move the smaller parent down and climb one level.
          mem_wdata = ra_data;
          pos_d     = parent_pos;
          ra_pos    = CW'(parent_pos >> 1);
          state_d   = (parent_pos > CNT_W'(1)) ? S_INS_CMP : S_INS_WR;
        end else begin
          mem_wdata = key_q;
          state_d   = S_DONE;
        end
      end

      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_wpos  = pos_q;
        mem_wdata = key_q;
        state_d   = S_DONE;
      end

      S_REM_LOAD: begin
        removed_d = ra_data;
        key_d     = rb_data;
        count_d   = count_dec;
        pos_d     = CNT_W'(1);
        child_d   = CW'(2);
        ra_pos    = CW'(2);
        rb_pos    = CW'(3);
        if (CW'(2) <= CW'(count_dec)) begin
          state_d = S_REM_CMP;
        end else begin
          mem_we    = 1'b1;
          mem_wpos  = CNT_W'(1);
          mem_wdata = rb_data;
          state_d   = S_DONE;
        end
      end

      S_REM_CMP: begin
        mem_we   = 1'b1;
        mem_wpos = pos_q;
        if (key_q >= sel_val) begin
          mem_wdata = key_q;
          state_d   = S_DONE;
        end else begin
          // Lift the larger child and descend to its place.
          mem_wdata = sel_val;
          pos_d     = CNT_W'(sel_pos);
          child_d   = next_child;
          ra_pos    = next_child;
          rb_pos    = next_child + CW'(1);
          state_d   = (next_child <= CW'(count_q)) ? S_REM_CMP : S_REM_WR;
        end
      end

      S_REM_WR: begin
        mem_we    = 1'b1;
        mem_wpos  = pos_q;
        mem_wdata = key_q;
        state_d   = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    child_q   <= child_d;
    key_q     <= key_d;
    removed_q <= removed_d;
    status_q  <= status_d;
  end

  // Output register: holds a finished result until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_status_q <= status_q;
      out_key_q    <= removed_q;
      out_count_q  <= count_ext[bmh_pkg::CAP_W-1:0];
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign out_status_o  = out_status_q;
  assign out_max_key_o = out_key_q;
  assign out_count_o   = out_count_q;

endmodule

`default_nettype wire

// ----- tb/tb_binary_max_heap_unit.sv -----
// Self-checking testbench of the binary max-heap unit with its own heap predictor.
`timescale 1ns / 1ps

module tb_binary_max_heap_unit;

  localparam int unsigned KEY_W = bmh_pkg::KEY_W;
  localparam int unsigned CAP_W = bmh_pkg::CAP_W;

  // The unit is built at its default depth, so a capacity above 1024 acts as 1024.
  localparam int unsigned HEAP_DEPTH = 1024;
  // Cycles without any beat on any channel before the run is declared hung. The longest
  // quiet stretch of a correct run is the deliberate receiver hold-off.
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  // Cycles to wait after the last result, which is ample for a full ten-level sift.
  localparam int unsigned SETTLE_CYCLES = 40;

  typedef struct packed {
    bmh_pkg::status_e         status;
    logic signed [KEY_W-1:0]  max_key;
    logic [CAP_W-1:0]         count;
  } heap_result_t;

  // Clock, reset and the ports of the unit. Every input has a known value from time zero.
  logic                     clk_i          = 1'b0;
  logic                     rst_ni         = 1'b0;
  logic                     cfg_valid_i    = 1'b0;
  logic                     cfg_ready_o;
  logic [CAP_W-1:0]         cfg_capacity_i = '0;
  logic                     in_valid_i     = 1'b0;
  logic                     in_stall_o;
  logic                     in_req_type_i  = bmh_pkg::REQ_INSERT;
  logic signed [KEY_W-1:0]  in_key_i       = '0;
  logic                     out_valid_o;
  logic                     out_stall_i    = 1'b0;
  logic [1:0]               out_status_o;
  logic signed [KEY_W-1:0]  out_max_key_o;
  logic [CAP_W-1:0]         out_count_o;

  // Predictor state: the heap as the unit should hold it, its count and the capacity register.
  logic signed [KEY_W-1:0]  heap_keys [1:HEAP_DEPTH];
  int unsigned              heap_count;
  int unsigned              heap_capacity;

  // Results that have been predicted for accepted requests and not yet seen on the output.
  heap_result_t             pending_results [$];

  // Idling percentages for the two sides, and the cycles left of a forced receiver hold-off.
  int unsigned              send_idle_pct;
  int unsigned              recv_idle_pct;
  int unsigned              stall_hold_left;
  int unsigned              mismatch_count;
  int unsigned              quiet_cycles;

  binary_max_heap_unit #(
    .HEAP_DEPTH(HEAP_DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_capacity_i(cfg_capacity_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_req_type_i (in_req_type_i),
    .in_key_i      (in_key_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_status_o  (out_status_o),
    .out_max_key_o (out_max_key_o),
    .out_count_o   (out_count_o)
  );

  // 20 ns period: ten high, ten low.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Works out the result of one request and moves the predicted heap on. An insert climbs
  // past strictly smaller parents only, so it comes to rest below an equal one. A removal
  // carries the former last key down from the root, taking the left child when both are
  // equal, and stops as soon as the carried key is not smaller than the larger child.
  function automatic heap_result_t predict_request(bmh_pkg::req_e req,
                                                   logic signed [KEY_W-1:0] key);
    heap_result_t             res;
    int unsigned              usable;
    int unsigned              slot;
    int unsigned              parent;
    int unsigned              child;
    logic signed [KEY_W-1:0]  moving;

    res.status  = bmh_pkg::ST_OK;
    res.max_key = '0;
    usable = (heap_capacity > HEAP_DEPTH) ? HEAP_DEPTH : heap_capacity;
    if (req == bmh_pkg::REQ_INSERT) begin
      if (heap_count >= usable) begin
        // A capacity lowered below the count refuses inserts until enough keys are removed.
        res.status = bmh_pkg::ST_FULL;
      end else begin
        heap_count++;
        slot = heap_count;
        while (slot > 1 && heap_keys[slot / 2] < key) begin
          heap_keys[slot] = heap_keys[slot / 2];
          slot = slot / 2;
        end
        heap_keys[slot] = key;
      end
    end else if (heap_count == 0) begin
      res.status = bmh_pkg::ST_EMPTY;
    end else begin
      moving      = heap_keys[heap_count];
      res.max_key = heap_keys[1];
      heap_count--;
      parent = 1;
      child  = 2;
      while (child <= heap_count) begin
        if (child < heap_count && heap_keys[child + 1] > heap_keys[child]) begin
          child++;
        end
        if (moving >= heap_keys[child]) begin
          break;
        end
        heap_keys[parent] = heap_keys[child];
        parent = child;
        child  = 2 * parent;
      end
      heap_keys[parent] = moving;
    end
    res.count = CAP_W'(heap_count);
    return res;
  endfunction

  // Keys are drawn so that duplicates, the extremes and the sign boundary turn up often,
  // alongside fully random 32-bit values that exercise every bit.
  function automatic logic signed [KEY_W-1:0] random_key();
    logic signed [KEY_W-1:0] key;

    case ($urandom_range(3))
      0: begin
        key = $urandom();
      end
      1: begin
        key = $signed($urandom_range(15)) - 8;
      end
      2: begin
        case ($urandom_range(3))
          0: key = 32'h7fff_ffff;
          1: key = 32'h8000_0000;
          2: key = 32'h0000_0000;
          default: key = 32'hffff_ffff;
        endcase
      end
      default: begin
        key = $signed($urandom_range(2000)) - 1000;
      end
    endcase
    return key;
  endfunction

  task automatic report_mismatch(string msg);
    $display("tb: mismatch at %0t ns: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Offers one request beat and returns at the edge on which it is taken. The valid line is
  // only lowered when a gap is wanted, so back-to-back beats keep it high throughout.
  task automatic send_request(bmh_pkg::req_e req, logic signed [KEY_W-1:0] key);
    int unsigned gap;

    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(6, 1);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    in_req_type_i <= req;
    in_key_i      <= key;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    pending_results.push_back(predict_request(req, key));
  endtask

  // Withdraws the request channel and waits until every predicted result has come back.
  // Every request yields a result, so an empty queue means the unit has nothing in hand.
  task automatic wait_until_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] value);
    wait_until_drained();
    cfg_valid_i    <= 1'b1;
    cfg_capacity_i <= value;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    cfg_valid_i   <= 1'b0;
    heap_capacity = value;
  endtask

  task automatic run_random_requests(int unsigned n, int unsigned insert_pct);
    bmh_pkg::req_e req;

    repeat (n) begin
      req = ($urandom_range(99) < insert_pct) ? bmh_pkg::REQ_INSERT : bmh_pkg::REQ_REMOVE;
      send_request(req, random_key());
    end
  endtask

  // Extreme keys, equal keys and removals from an empty heap at the reset capacity.
  task automatic test_directed_keys();
    send_request(bmh_pkg::REQ_REMOVE, 32'h1234_5678);
    send_request(bmh_pkg::REQ_INSERT, 32'h0000_0000);
    send_request(bmh_pkg::REQ_INSERT, 32'h7fff_ffff);
    send_request(bmh_pkg::REQ_INSERT, 32'h8000_0000);
    send_request(bmh_pkg::REQ_INSERT, 32'hffff_ffff);
    send_request(bmh_pkg::REQ_INSERT, 32'sd5);
    send_request(bmh_pkg::REQ_INSERT, 32'sd5);
    repeat (6) send_request(bmh_pkg::REQ_REMOVE, $urandom());
    send_request(bmh_pkg::REQ_REMOVE, 32'hffff_ffff);
  endtask

  // Capacity of one and of zero, a capacity beyond the depth, and a capacity lowered
  // beneath the number of keys already held.
  task automatic test_capacity_edges();
    write_capacity(CAP_W'(1));
    send_request(bmh_pkg::REQ_INSERT, 32'sd42);
    send_request(bmh_pkg::REQ_INSERT, 32'sd43);
    send_request(bmh_pkg::REQ_REMOVE, 32'sd0);
    write_capacity(CAP_W'(0));
    send_request(bmh_pkg::REQ_INSERT, 32'sd7);
    write_capacity(CAP_W'(2047));
    send_request(bmh_pkg::REQ_INSERT, 32'sd3);
    send_request(bmh_pkg::REQ_INSERT, 32'sd9);
    send_request(bmh_pkg::REQ_INSERT, 32'sd1);
    write_capacity(CAP_W'(1));
    send_request(bmh_pkg::REQ_INSERT, 32'sd100);
    send_request(bmh_pkg::REQ_REMOVE, 32'sd0);
    write_capacity(CAP_W'(1024));
    send_request(bmh_pkg::REQ_REMOVE, 32'sd0);
    send_request(bmh_pkg::REQ_REMOVE, 32'sd0);
  endtask

  // Small heaps, so that full and empty both come up again and again.
  task automatic test_random_small_capacity();
    repeat (4) begin
      write_capacity(CAP_W'($urandom_range(48, 1)));
      run_random_requests(100, 60);
    end
  endtask

  // Any capacity the register can hold, with the count carried over from before.
  task automatic test_random_any_capacity();
    repeat (2) begin
      write_capacity(CAP_W'($urandom_range(2047)));
      run_random_requests(125, 50);
    end
  endtask

  // The receiver holds off for a long stretch while requests keep coming, so the unit
  // ends up with one result parked and another finished, and has to stall its input.
  task automatic test_output_backpressure();
    write_capacity(CAP_W'(1024));
    stall_hold_left = 300;
    run_random_requests(10, 70);
  endtask

  // Nearly all inserts at the largest capacity, so the heap reaches its full depth and
  // sifts run through every level, with a capacity above the depth standing in for it.
  task automatic test_fill_to_depth();
    write_capacity(CAP_W'(2047));
    run_random_requests(1080, 99);
  endtask

  // With the heap near its depth, the capacity drops to one: inserts are refused until
  // the count falls, while removals from a deep heap carry on as usual.
  task automatic test_capacity_below_count();
    write_capacity(CAP_W'(1));
    run_random_requests(40, 30);
  endtask

  // The receiver stalls at random, except while a hold-off is running, which it counts down.
  always @(posedge clk_i) begin
    if (stall_hold_left > 0) begin
      out_stall_i <= 1'b1;
      stall_hold_left--;
    end else begin
      out_stall_i <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Each result beat is compared field by field with the oldest prediction.
  always @(posedge clk_i) begin
    heap_result_t want;

    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat with no request waiting (status %0d)",
                                  out_status_o));
      end else begin
        want = pending_results.pop_front();
        if (out_status_o !== want.status) begin
          report_mismatch($sformatf("status got %0d want %0d", out_status_o, want.status));
        end
        if (out_max_key_o !== want.max_key) begin
          report_mismatch($sformatf("max_key got %0d want %0d", out_max_key_o, want.max_key));
        end
        if (out_count_o !== want.count) begin
          report_mismatch($sformatf("count got %0d want %0d", out_count_o, want.count));
        end
      end
    end
  end

  // Any beat on any channel counts as progress; a long run of quiet cycles means a hang.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    heap_count      = 0;
    heap_capacity   = 1024;
    send_idle_pct   = 17;
    recv_idle_pct   = 74;
    stall_hold_left = 0;
    mismatch_count  = 0;
    quiet_cycles    = 0;

    // Reset is held from time zero and released on a clock edge, once only.
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // First the sender idles rarely and the receiver often.
    test_directed_keys();
    test_capacity_edges();
    test_random_small_capacity();

    // Then the other way round.
    send_idle_pct = 74;
    recv_idle_pct = 17;
    test_random_any_capacity();

    // Then neither side idles, apart from the deliberate hold-off.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_backpressure();
    test_fill_to_depth();
    test_capacity_below_count();

    wait_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
